// File: design/bcc_pkg.sv
// shared types and constants for the button click classifier
package bcc_pkg;

    // tick counter width, thresholds are used modulo 2^CNT_W
    localparam int CNT_W = 16;
    // width of each threshold register
    localparam int CFG_W = 16;
    // configuration index width
    localparam int CFG_IDX_W = 2;
    // stream data widths, whole bytes
    localparam int S_DATA_W = 8;
    localparam int M_DATA_W = 8;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_GAP = 2'd2;

    // reset values of the thresholds
    localparam logic [CFG_W-1:0] DEBOUNCE_RST   = 16'd20;
    localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd1000;
    localparam logic [CFG_W-1:0] DOUBLE_GAP_RST = 16'd300;

    // click event codes
    typedef enum logic [1:0] {
        EV_NONE   = 2'd0,
        EV_SINGLE = 2'd1,
        EV_DOUBLE = 2'd2,
        EV_LONG   = 2'd3
    } event_t;

    // classifier phases, one-hot
    typedef enum logic [6:0] {
        PH_IDLE      = 7'b0000001,
        PH_DB_RISE   = 7'b0000010,
        PH_PRESSED   = 7'b0000100,
        PH_DB_FALL   = 7'b0001000,
        PH_RELEASED  = 7'b0010000,
        PH_DB_SECOND = 7'b0100000,
        PH_LONG      = 7'b1000000
    } phase_t;

    // threshold set handed to the classifier core
    typedef struct packed {
        logic [CFG_W-1:0] debounce_ticks;
        logic [CFG_W-1:0] long_press_ticks;
        logic [CFG_W-1:0] double_gap_ticks;
    } cfg_t;

endpackage

// File: design/bcc_cfg.sv
// threshold register file written through the configuration channel
module bcc_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]     cfg_data,
    output bcc_pkg::cfg_t                 cfg
);

    bcc_pkg::cfg_t cfg_reg;

    // always able to take a write
    assign cfg_ready = 1'b1;

    // register writes, unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks   <= bcc_pkg::DEBOUNCE_RST;
            cfg_reg.long_press_ticks <= bcc_pkg::LONG_PRESS_RST;
            cfg_reg.double_gap_ticks <= bcc_pkg::DOUBLE_GAP_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                bcc_pkg::REG_DEBOUNCE:   cfg_reg.debounce_ticks   <= cfg_data;
                bcc_pkg::REG_LONG_PRESS: cfg_reg.long_press_ticks <= cfg_data;
                bcc_pkg::REG_DOUBLE_GAP: cfg_reg.double_gap_ticks <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: design/bcc_core.sv
// click classifier state: tick counter, mark time and phase machine
module bcc_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  logic              level,
    input  bcc_pkg::cfg_t     cfg,
    output bcc_pkg::event_t   click_event
);

    bcc_pkg::phase_t           phase_reg, phase_next;
    logic [bcc_pkg::CNT_W-1:0] tick_reg, tick_next;
    logic [bcc_pkg::CNT_W-1:0] mark_reg, mark_next;
    logic                      hit_debounce, hit_long, hit_gap;

    // counter advances before anything is judged
    assign tick_next = tick_reg + 1'b1;

    // threshold reached, exact match under wrap
    assign hit_debounce = (bcc_pkg::CNT_W'(mark_reg + bcc_pkg::CNT_W'(cfg.debounce_ticks)))
                          == tick_next;
    assign hit_long     = (bcc_pkg::CNT_W'(mark_reg + bcc_pkg::CNT_W'(cfg.long_press_ticks)))
                          == tick_next;
    assign hit_gap      = (bcc_pkg::CNT_W'(mark_reg + bcc_pkg::CNT_W'(cfg.double_gap_ticks)))
                          == tick_next;

    // phase machine
    always_comb begin
        phase_next  = phase_reg;
        mark_next   = mark_reg;
        click_event = bcc_pkg::EV_NONE;
        case (phase_reg)
            bcc_pkg::PH_IDLE: begin
                if (level) begin
                    phase_next = bcc_pkg::PH_DB_RISE;
                    mark_next  = tick_next;
                end
            end
            bcc_pkg::PH_DB_RISE: begin
                if (hit_debounce) begin
                    if (level) begin
                        phase_next = bcc_pkg::PH_PRESSED;
                        mark_next  = tick_next;
                    end else begin
                        phase_next = bcc_pkg::PH_IDLE;
                    end
                end
            end
            bcc_pkg::PH_PRESSED: begin
                if (level) begin
                    if (hit_long) begin
                        phase_next  = bcc_pkg::PH_LONG;
                        click_event = bcc_pkg::EV_LONG;
                    end
                end else begin
                    phase_next = bcc_pkg::PH_DB_FALL;
                    mark_next  = tick_next;
                end
            end
            bcc_pkg::PH_DB_FALL: begin
                // a bounce back high keeps the mark taken at the release
                if (hit_debounce) begin
                    if (level) begin
                        phase_next = bcc_pkg::PH_PRESSED;
                    end else begin
                        phase_next = bcc_pkg::PH_RELEASED;
                        mark_next  = tick_next;
                    end
                end
            end
            bcc_pkg::PH_RELEASED: begin
                if (level) begin
                    phase_next = bcc_pkg::PH_DB_SECOND;
                    mark_next  = tick_next;
                end else if (hit_gap) begin
                    phase_next  = bcc_pkg::PH_IDLE;
                    click_event = bcc_pkg::EV_SINGLE;
                end
            end
            bcc_pkg::PH_DB_SECOND: begin
                if (hit_debounce) begin
                    phase_next  = bcc_pkg::PH_IDLE;
                    click_event = level ? bcc_pkg::EV_DOUBLE : bcc_pkg::EV_SINGLE;
                end
            end
            bcc_pkg::PH_LONG: begin
                if (level) begin
                    click_event = bcc_pkg::EV_LONG;
                end else begin
                    phase_next = bcc_pkg::PH_IDLE;
                end
            end
            default: begin
                phase_next = bcc_pkg::PH_IDLE;
            end
        endcase
    end

    // state moves once per processed sample
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bcc_pkg::PH_IDLE;
            tick_reg  <= '0;
            mark_reg  <= '0;
        end else if (advance) begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            mark_reg  <= mark_next;
        end
    end

endmodule

// File: design/button_click_classifier_top.sv
// top level of the button click classifier with stream and configuration ports
// One button sample enters per clock and one click event leaves per sample,
// in order. A sample is captured in an input register, classified by the phase
// machine and held in an output register; the sustained rate is one sample per
// cycle while the result side keeps m_tready high, and the phase machine updates
// once per sample and sets that rate. Thresholds (debounce, long press, double
// gap) are written through the cfg_ port, index 0, 1 and 2, and should only be
// changed while no samples are in flight. Writes to index 3 are ignored.
module button_click_classifier_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    // sample stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bcc_pkg::S_DATA_W-1:0]  s_tdata,   // [0] button_level, rest zero
    // event stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bcc_pkg::M_DATA_W-1:0]  m_tdata,   // [1:0] click_event, rest zero
    // configuration writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [bcc_pkg::CFG_W-1:0]     cfg_data
);

    logic            in_valid_reg;
    logic            in_level_reg;
    logic            out_valid_reg;
    bcc_pkg::event_t out_event_reg;
    logic            advance;
    bcc_pkg::cfg_t   cfg;
    bcc_pkg::event_t click_event;

    // input stage moves on when the output register is free or draining
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_level_reg <= s_tdata[0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_event_reg <= click_event;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(bcc_pkg::M_DATA_W-2){1'b0}}, out_event_reg};

    bcc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    bcc_core u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .level       (in_level_reg),
        .cfg         (cfg),
        .click_event (click_event)
    );

endmodule

// File: design/bcc_checker.sv
// port-level checks for the button click classifier, bound to the top level
module bcc_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tvalid,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [bcc_pkg::M_DATA_W-1:0] m_tdata
);

    // a stalled event transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("event transaction changed while stalled");

    // reset empties the output
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("event valid after reset");

    // with nothing waiting at the output a sample is always taken
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("sample refused with empty output");

    // a new event comes from an accepted sample that passed through the input register
    a_event_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("event without a matching sample");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/button_click_classifier_top_test.sv
`timescale 1ns / 100ps
// self-checking testbench for the button click classifier top level
module button_click_classifier_top_test;

    localparam int RESULT_LATENCY    = 2;
    localparam int LONG_STALL_CYCLES = 60;
    // index with no register behind it, writes there are dropped
    localparam logic [bcc_pkg::CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    // clock and block ports, all inputs known from time zero
    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [bcc_pkg::S_DATA_W-1:0]  s_tdata   = '0;   // [0] button_level
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [bcc_pkg::M_DATA_W-1:0]  m_tdata;          // [1:0] click_event
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [bcc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [bcc_pkg::CFG_W-1:0]     cfg_data  = '0;

    always #10 aclk = ~aclk;

    button_click_classifier_top DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // classifier state mirrored by the predictor
    bcc_pkg::phase_t           click_phase    = bcc_pkg::PH_IDLE;
    logic [bcc_pkg::CNT_W-1:0] tick_now       = '0;
    logic [bcc_pkg::CNT_W-1:0] mark_tick      = '0;
    logic [bcc_pkg::CFG_W-1:0] cfg_debounce   = bcc_pkg::DEBOUNCE_RST;
    logic [bcc_pkg::CFG_W-1:0] cfg_long_press = bcc_pkg::LONG_PRESS_RST;
    logic [bcc_pkg::CFG_W-1:0] cfg_double_gap = bcc_pkg::DOUBLE_GAP_RST;

    // events still owed by the block, oldest first
    bcc_pkg::event_t expected_events [$];
    bcc_pkg::event_t want;

    int  send_idle_pct  = 6;
    int  recv_idle_pct  = 88;
    bit  stall_request  = 1'b0;
    int  mismatch_count = 0;
    int  samples_sent   = 0;
    int  regs_written   = 0;
    int  singles_seen   = 0;
    int  doubles_seen   = 0;
    int  longs_seen     = 0;

    // directed stimulus: samples and register writes in order
    typedef enum logic {STEP_SAMPLE, STEP_WRITE} step_kind_t;
    typedef struct packed {
        step_kind_t                    kind;
        logic [bcc_pkg::CFG_IDX_W-1:0] reg_index;
        logic [bcc_pkg::CFG_W-1:0]     reg_value;
        logic                          level;
        logic                          typed;        // expected event given in the row
        bcc_pkg::event_t               typed_event;
    } directed_step_t;

    directed_step_t directed_steps [30] = '{
        // idle right after reset
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b1, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b1, bcc_pkg::EV_NONE},
        // unused index must leave every threshold alone
        '{STEP_WRITE,  REG_UNUSED,              16'hFFFF, 1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_WRITE,  bcc_pkg::REG_DEBOUNCE,   16'd1,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_WRITE,  bcc_pkg::REG_LONG_PRESS, 16'd3,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_WRITE,  bcc_pkg::REG_DOUBLE_GAP, 16'd2,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        // rise that bounces back to idle
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        // press, false release, release, single
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        // press, release, second press, double
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        // hold into a long click, repeated while held
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b1, 1'b0, bcc_pkg::EV_NONE},
        '{STEP_SAMPLE, bcc_pkg::REG_DEBOUNCE,   16'd0,    1'b0, 1'b0, bcc_pkg::EV_NONE}
    };

    // exact match of mark plus threshold with the wrapping tick count
    function automatic bit threshold_hit(input logic [bcc_pkg::CFG_W-1:0] thr);
        return bcc_pkg::CNT_W'(mark_tick + thr) == tick_now;
    endfunction

    // advance the mirrored classifier by one sample and return its event
    function automatic bcc_pkg::event_t predict_event(input logic level);
        bcc_pkg::event_t ev;
        ev = bcc_pkg::EV_NONE;
        tick_now = tick_now + 1'b1;
        case (click_phase)
            bcc_pkg::PH_IDLE: begin
                if (level) begin
                    click_phase = bcc_pkg::PH_DB_RISE;
                    mark_tick   = tick_now;
                end
            end
            bcc_pkg::PH_DB_RISE: begin
                if (threshold_hit(cfg_debounce)) begin
                    if (level) begin
                        click_phase = bcc_pkg::PH_PRESSED;
                        mark_tick   = tick_now;
                    end else begin
                        click_phase = bcc_pkg::PH_IDLE;
                    end
                end
            end
            bcc_pkg::PH_PRESSED: begin
                if (!level) begin
                    click_phase = bcc_pkg::PH_DB_FALL;
                    mark_tick   = tick_now;
                end else if (threshold_hit(cfg_long_press)) begin
                    click_phase = bcc_pkg::PH_LONG;
                    ev          = bcc_pkg::EV_LONG;
                end
            end
            bcc_pkg::PH_DB_FALL: begin
                // a high level here is a false release, mark stays put
                if (threshold_hit(cfg_debounce)) begin
                    if (level) begin
                        click_phase = bcc_pkg::PH_PRESSED;
                    end else begin
                        click_phase = bcc_pkg::PH_RELEASED;
                        mark_tick   = tick_now;
                    end
                end
            end
            bcc_pkg::PH_RELEASED: begin
                if (level) begin
                    click_phase = bcc_pkg::PH_DB_SECOND;
                    mark_tick   = tick_now;
                end else if (threshold_hit(cfg_double_gap)) begin
                    click_phase = bcc_pkg::PH_IDLE;
                    ev          = bcc_pkg::EV_SINGLE;
                end
            end
            bcc_pkg::PH_DB_SECOND: begin
                if (threshold_hit(cfg_debounce)) begin
                    click_phase = bcc_pkg::PH_IDLE;
                    ev          = level ? bcc_pkg::EV_DOUBLE : bcc_pkg::EV_SINGLE;
                end
            end
            bcc_pkg::PH_LONG: begin
                if (level)
                    ev = bcc_pkg::EV_LONG;
                else
                    click_phase = bcc_pkg::PH_IDLE;
            end
            default: click_phase = bcc_pkg::PH_IDLE;
        endcase
        return ev;
    endfunction

    function automatic void log_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("ERROR at %0t: %s", $realtime, msg);
    endfunction

    // offer one sample, with random idle cycles ahead of it
    task automatic send_level(input logic level, input logic typed = 1'b0,
                              input bcc_pkg::event_t typed_event = bcc_pkg::EV_NONE);
        bcc_pkg::event_t predicted;
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(bcc_pkg::S_DATA_W-1){1'b0}}, level};
        do @(posedge aclk); while (!s_tready);
        predicted = predict_event(level);
        expected_events.push_back(typed ? typed_event : predicted);
        samples_sent++;
    endtask

    task automatic hold_level(input logic level, input int count);
        repeat (count) send_level(level);
    endtask

    // stop offering and let every owed event come out
    task automatic wait_idle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0) @(posedge aclk);
        repeat (RESULT_LATENCY + 2) @(posedge aclk);
    endtask

    // one configuration transaction, mirrored into the predictor
    task automatic write_reg(input logic [bcc_pkg::CFG_IDX_W-1:0] idx,
                             input logic [bcc_pkg::CFG_W-1:0] value);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            bcc_pkg::REG_DEBOUNCE:   cfg_debounce   = value;
            bcc_pkg::REG_LONG_PRESS: cfg_long_press = value;
            bcc_pkg::REG_DOUBLE_GAP: cfg_double_gap = value;
            default: ;
        endcase
        regs_written++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_thresholds(input int debounce, input int long_press, input int gap);
        wait_idle();
        write_reg(bcc_pkg::REG_DEBOUNCE, bcc_pkg::CFG_W'(debounce));
        write_reg(bcc_pkg::REG_LONG_PRESS, bcc_pkg::CFG_W'(long_press));
        write_reg(bcc_pkg::REG_DOUBLE_GAP, bcc_pkg::CFG_W'(gap));
    endtask

    // a press gesture sized around the current thresholds, or plain noise
    task automatic play_gesture();
        int d;
        int l;
        int g;
        d = int'(cfg_debounce);
        l = int'(cfg_long_press);
        g = int'(cfg_double_gap);
        if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(1, 8)) send_level(1'($urandom_range(1)));
        end else begin
            hold_level(1'b1, $urandom_range(1, d + l + 4));
            // bounce during the press
            if ($urandom_range(3) == 0) begin
                hold_level(1'b0, $urandom_range(1, d + 1));
                hold_level(1'b1, $urandom_range(1, d + 3));
            end
            hold_level(1'b0, $urandom_range(1, d + 2));
            // second press, possibly too short
            if ($urandom_range(2) == 0)
                hold_level(1'b1, $urandom_range(1, d + 3));
            hold_level(1'b0, $urandom_range(d + 1, d + g + 3));
        end
    endtask

    task automatic run_gestures(input int count);
        int start;
        start = samples_sent;
        while (samples_sent - start < count) play_gesture();
    endtask

    // result side ready, with random idling and one long hold-off on request
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_request) begin
                stall_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_STALL_CYCLES) @(negedge aclk);
            end
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // compare each event transaction with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_events.size() == 0) begin
                log_mismatch($sformatf("click_event %0d arrived with nothing owed",
                                       m_tdata[1:0]));
            end else begin
                want = expected_events.pop_front();
                if (m_tdata[1:0] !== want)
                    log_mismatch($sformatf("click_event expected %s (%0d), got %0d",
                                           want.name(), want, m_tdata[1:0]));
                case (want)
                    bcc_pkg::EV_SINGLE: singles_seen++;
                    bcc_pkg::EV_DOUBLE: doubles_seen++;
                    bcc_pkg::EV_LONG:   longs_seen++;
                    default: ;
                endcase
            end
        end
    end

    // run limit
    initial begin
        #2ms;
        $display("timeout with %0d events still owed", expected_events.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // reset, directed steps, then random phases under changing idle patterns
    initial begin
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_steps[i]) begin
            if (directed_steps[i].kind == STEP_WRITE) begin
                wait_idle();
                write_reg(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end else begin
                send_level(directed_steps[i].level, directed_steps[i].typed,
                           directed_steps[i].typed_event);
            end
        end

        // short thresholds, slow receiver, one long hold-off midway
        apply_thresholds($urandom_range(1, 3), $urandom_range(4, 16), $urandom_range(2, 10));
        run_gestures(100);
        stall_request = 1'b1;
        run_gestures(120);

        // slow sender, smallest nonzero thresholds then medium ones
        wait_idle();
        send_idle_pct = 88;
        recv_idle_pct = 6;
        apply_thresholds(1, 1, 1);
        run_gestures(180);
        apply_thresholds($urandom_range(2, 5), $urandom_range(10, 30), $urandom_range(5, 20));
        run_gestures(180);

        // no idling: zero debounce is never reached short of a full counter wrap
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        apply_thresholds(0, 16'hFFFF, 3);
        hold_level(1'b1, 20);
        hold_level(1'b0, 2);

        // back to the power-on thresholds
        apply_thresholds(int'(bcc_pkg::DEBOUNCE_RST), int'(bcc_pkg::LONG_PRESS_RST),
                         int'(bcc_pkg::DOUBLE_GAP_RST));
        hold_level(1'b1, 8);
        hold_level(1'b0, 4);

        wait_idle();
        $display("%0d samples classified over %0d register writes", samples_sent, regs_written);
        $display("events checked: %0d single, %0d double, %0d long; %0d mismatches",
                 singles_seen, doubles_seen, longs_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: button_click_classifier_top.f
design/bcc_pkg.sv
design/bcc_cfg.sv
design/bcc_core.sv
design/button_click_classifier_top.sv
design/bcc_checker.sv
sim/button_click_classifier_top_test.sv
